// ===== design/utf8_stream_decoder_macros.svh =====
// ----------------------------------------------------------------------------
// utf8 stream decoder assertion macros
// shared assertion forms for the decoder blocks
// ----------------------------------------------------------------------------
`ifndef UTF8_STREAM_DECODER_MACROS_SVH
`define UTF8_STREAM_DECODER_MACROS_SVH

// same-cycle implication, disabled while reset is held
`define U8D_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("u8d assertion failed");

// next-cycle implication, disabled while reset is held
`define U8D_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("u8d assertion failed");

`endif

// ===== design/u8d_pkg.sv =====
// ----------------------------------------------------------------------------
// u8d_pkg
// types and constants shared by the utf-8 stream decoder modules
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package u8d_pkg;

    localparam int Q_DEPTH_DEF = 2;

    localparam logic [1:0] ST_PENDING = 2'd0;
    localparam logic [1:0] ST_DONE    = 2'd1;
    localparam logic [1:0] ST_ILLEGAL = 2'd2;

    localparam logic [7:0] B_CONT_HI  = 8'hBF;
    localparam logic [7:0] B_LEAD2_LO = 8'hC2;
    localparam logic [7:0] B_LEAD2_HI = 8'hDF;
    localparam logic [7:0] B_LEAD3_LO = 8'hE0;
    localparam logic [7:0] B_LEAD3_HI = 8'hEF;
    localparam logic [7:0] B_LEAD4_LO = 8'hF0;
    localparam logic [7:0] B_LEAD4_HI = 8'hF4;
    localparam logic [7:0] B_E0       = 8'hE0;
    localparam logic [7:0] B_ED       = 8'hED;
    localparam logic [7:0] B_F0       = 8'hF0;
    localparam logic [7:0] B_F4       = 8'hF4;
    localparam logic [7:0] B_SEC_A0   = 8'hA0;
    localparam logic [7:0] B_SEC_9F   = 8'h9F;
    localparam logic [7:0] B_SEC_90   = 8'h90;
    localparam logic [7:0] B_SEC_8F   = 8'h8F;

    localparam logic [20:0] CP_MIN_2  = 21'h00080;
    localparam logic [20:0] CP_MIN_3  = 21'h00800;
    localparam logic [20:0] CP_MIN_4  = 21'h10000;
    localparam logic [20:0] CP_MAX    = 21'h10FFFF;
    localparam logic [20:0] CP_SUR_LO = 21'h0D800;
    localparam logic [20:0] CP_SUR_HI = 21'h0DFFF;

    typedef enum logic [2:0] {
        K_ASCII = 3'd0,
        K_CONT  = 3'd1,
        K_LEAD2 = 3'd2,
        K_LEAD3 = 3'd3,
        K_LEAD4 = 3'd4,
        K_BAD   = 3'd5
    } t_kind;

    typedef enum logic [2:0] {
        RNG_FULL = 3'd0,
        RNG_E0   = 3'd1,
        RNG_ED   = 3'd2,
        RNG_F0   = 3'd3,
        RNG_F4   = 3'd4
    } t_range;

    typedef struct packed {
        logic [7:0] data_byte;
        t_kind      kind;
        t_range     range;
        logic       ge_a0;
        logic       le_9f;
        logic       ge_90;
        logic       le_8f;
    } t_cls;

    typedef struct packed {
        logic [1:0]  status;
        logic [20:0] code_point;
        logic [2:0]  seq_length;
    } t_res;

endpackage

// ===== design/u8d_queue.sv =====
// ----------------------------------------------------------------------------
// u8d_queue
// small register queue, push/full on one side and pop/empty on the other
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module u8d_queue #(
    parameter int DEPTH = u8d_pkg::Q_DEPTH_DEF,
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_data
);
    import u8d_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [PTR_W-1:0] n_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             wr_en;
    logic             rd_en;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (wr_en) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (rd_en) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (wr_en && !rd_en) begin
            n_count = r_count + CNT_W'(1);
        end else if (rd_en && !wr_en) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ===== design/u8d_front.sv =====
// ----------------------------------------------------------------------------
// u8d_front
// byte intake: classifies each word as ascii, lead, continuation or bad
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module u8d_front (
    input  logic          i_push,
    input  logic [7:0]    i_data_byte,
    output logic          o_full,
    input  logic          i_q_full,
    output logic          o_q_push,
    output u8d_pkg::t_cls o_cls
);
    import u8d_pkg::*;

    t_kind  kind;
    t_range range;

    assign o_full   = i_q_full;
    assign o_q_push = i_push;

    always_comb begin
        kind  = K_BAD;
        range = RNG_FULL;
        if (!i_data_byte[7]) begin
            kind = K_ASCII;
        end else if (i_data_byte <= B_CONT_HI) begin
            kind = K_CONT;
        end else if (i_data_byte >= B_LEAD2_LO && i_data_byte <= B_LEAD2_HI) begin
            kind = K_LEAD2;
        end else if (i_data_byte >= B_LEAD3_LO && i_data_byte <= B_LEAD3_HI) begin
            kind = K_LEAD3;
            if (i_data_byte == B_E0) begin
                range = RNG_E0;
            end else if (i_data_byte == B_ED) begin
                range = RNG_ED;
            end
        end else if (i_data_byte >= B_LEAD4_LO && i_data_byte <= B_LEAD4_HI) begin
            kind = K_LEAD4;
            if (i_data_byte == B_F0) begin
                range = RNG_F0;
            end else if (i_data_byte == B_F4) begin
                range = RNG_F4;
            end
        end
    end

    always_comb begin
        o_cls.data_byte = i_data_byte;
        o_cls.kind      = kind;
        o_cls.range     = range;
        o_cls.ge_a0     = (i_data_byte >= B_SEC_A0);
        o_cls.le_9f     = (i_data_byte <= B_SEC_9F);
        o_cls.ge_90     = (i_data_byte >= B_SEC_90);
        o_cls.le_8f     = (i_data_byte <= B_SEC_8F);
    end

endmodule

// ===== design/u8d_back.sv =====
// ----------------------------------------------------------------------------
// u8d_back
// sequence state: gathers payload bits and emits one result per word
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "utf8_stream_decoder_macros.svh"

module u8d_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  u8d_pkg::t_cls i_cls,
    output logic          o_take,
    input  logic          i_out_full,
    output logic          o_push,
    output u8d_pkg::t_res o_res
);
    import u8d_pkg::*;

    logic [1:0]  r_rem;
    logic [1:0]  n_rem;
    logic [2:0]  r_total;
    logic [2:0]  n_total;
    logic        r_second;
    logic        n_second;
    logic [20:0] r_acc;
    logic [20:0] n_acc;
    t_range      r_range;
    t_range      n_range;
    t_range      eff_range;
    logic        rng_ok;
    logic [20:0] shifted;

    assign o_take    = i_valid && !i_out_full;
    assign o_push    = o_take;
    assign eff_range = r_second ? r_range : RNG_FULL;
    assign shifted   = {r_acc[14:0], i_cls.data_byte[5:0]};

    always_comb begin
        case (eff_range)
            RNG_E0:  rng_ok = i_cls.ge_a0;
            RNG_ED:  rng_ok = i_cls.le_9f;
            RNG_F0:  rng_ok = i_cls.ge_90;
            RNG_F4:  rng_ok = i_cls.le_8f;
            default: rng_ok = 1'b1;
        endcase
    end

    always_comb begin
        n_rem    = r_rem;
        n_total  = r_total;
        n_second = r_second;
        n_acc    = r_acc;
        n_range  = r_range;
        o_res    = '{status: ST_PENDING, code_point: '0, seq_length: '0};
        if (o_take) begin
            if (r_rem == 2'd0) begin
                case (i_cls.kind)
                    K_ASCII: begin
                        o_res.status     = ST_DONE;
                        o_res.code_point = {13'd0, i_cls.data_byte};
                        o_res.seq_length = 3'd1;
                    end
                    K_LEAD2: begin
                        n_rem    = 2'd1;
                        n_total  = 3'd2;
                        n_second = 1'b1;
                        n_acc    = {16'd0, i_cls.data_byte[4:0]};
                        n_range  = RNG_FULL;
                    end
                    K_LEAD3: begin
                        n_rem    = 2'd2;
                        n_total  = 3'd3;
                        n_second = 1'b1;
                        n_acc    = {17'd0, i_cls.data_byte[3:0]};
                        n_range  = i_cls.range;
                    end
                    K_LEAD4: begin
                        n_rem    = 2'd3;
                        n_total  = 3'd4;
                        n_second = 1'b1;
                        n_acc    = {18'd0, i_cls.data_byte[2:0]};
                        n_range  = i_cls.range;
                    end
                    default: begin
                        o_res.status = ST_ILLEGAL;
                    end
                endcase
            end else if (i_cls.kind != K_CONT || !rng_ok) begin
                o_res.status = ST_ILLEGAL;
                n_rem        = 2'd0;
                n_total      = 3'd0;
                n_second     = 1'b0;
                n_acc        = '0;
                n_range      = RNG_FULL;
            end else if (r_rem == 2'd1) begin
                o_res.status     = ST_DONE;
                o_res.code_point = shifted;
                o_res.seq_length = r_total;
                n_rem            = 2'd0;
                n_total          = 3'd0;
                n_second         = 1'b0;
                n_acc            = '0;
                n_range          = RNG_FULL;
            end else begin
                n_rem    = r_rem - 2'd1;
                n_second = 1'b0;
                n_acc    = shifted;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem    <= 2'd0;
            r_total  <= 3'd0;
            r_second <= 1'b0;
            r_acc    <= '0;
            r_range  <= RNG_FULL;
        end else begin
            r_rem    <= n_rem;
            r_total  <= n_total;
            r_second <= n_second;
            r_acc    <= n_acc;
            r_range  <= n_range;
        end
    end

    `U8D_ASSERT_IMP(a_idle_clear, r_rem == 2'd0, r_acc == '0 && r_total == 3'd0 && !r_second)
    `U8D_ASSERT_IMP(a_nondone_zero, o_push && o_res.status != ST_DONE,
        o_res.code_point == '0 && o_res.seq_length == 3'd0)
    `U8D_ASSERT_IMP(a_no_overlong, o_push && o_res.status == ST_DONE,
        (o_res.seq_length == 3'd1 && o_res.code_point < CP_MIN_2) ||
        (o_res.seq_length == 3'd2 && o_res.code_point >= CP_MIN_2 &&
         o_res.code_point < CP_MIN_3) ||
        (o_res.seq_length == 3'd3 && o_res.code_point >= CP_MIN_3 &&
         o_res.code_point < CP_MIN_4 &&
         (o_res.code_point < CP_SUR_LO || o_res.code_point > CP_SUR_HI)) ||
        (o_res.seq_length == 3'd4 && o_res.code_point >= CP_MIN_4 &&
         o_res.code_point <= CP_MAX))
    `U8D_ASSERT_NXT(a_rem_step, o_take && r_rem != 2'd0 && o_res.status == ST_PENDING,
        r_rem == $past(r_rem) - 2'd1 && !r_second)

endmodule

// ===== design/utf8_stream_decoder.sv =====
// ----------------------------------------------------------------------------
// utf8_stream_decoder
// strict utf-8 decoder, one byte in and one result out per word
// ----------------------------------------------------------------------------
// Takes one byte per cycle and returns one result per byte, in order: pending,
// complete (code point and sequence length) or illegal. Sustained rate is one
// byte per cycle with neither side stalling. An accepted byte is written to the
// intake queue; the back end takes it from the head of that queue and writes its
// result to the result queue, stalling while the result queue is full, and the
// result is popped from the head of the result queue. Both queues hold Q_DEPTH words
// each. The decoder state is a single register set updated once per byte.
// Illegal bytes drop the partial sequence and the decoder waits for a new lead
// byte.
`timescale 1ns / 1ps

module utf8_stream_decoder #(
    parameter int Q_DEPTH = u8d_pkg::Q_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_data_byte,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  o_status,
    output logic [20:0] o_code_point,
    output logic [2:0]  o_seq_length
);
    import u8d_pkg::*;

    localparam int CLS_W = $bits(t_cls);
    localparam int RES_W = $bits(t_res);

    logic             in_q_full;
    logic             in_q_push;
    t_cls             front_cls;
    logic             in_q_empty;
    logic [CLS_W-1:0] in_q_data;
    t_cls             back_cls;
    logic             back_take;
    logic             out_q_full;
    logic             back_push;
    t_res             back_res;
    logic [RES_W-1:0] out_q_data;
    t_res             head_res;

    u8d_front u_front (
        .i_push      (push),
        .i_data_byte (i_data_byte),
        .o_full      (full),
        .i_q_full    (in_q_full),
        .o_q_push    (in_q_push),
        .o_cls       (front_cls)
    );

    u8d_queue #(
        .DEPTH (Q_DEPTH),
        .WIDTH (CLS_W)
    ) u_in_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (in_q_push),
        .i_data  (front_cls),
        .o_full  (in_q_full),
        .i_pop   (back_take),
        .o_empty (in_q_empty),
        .o_data  (in_q_data)
    );

    assign back_cls = t_cls'(in_q_data);

    u8d_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (!in_q_empty),
        .i_cls      (back_cls),
        .o_take     (back_take),
        .i_out_full (out_q_full),
        .o_push     (back_push),
        .o_res      (back_res)
    );

    u8d_queue #(
        .DEPTH (Q_DEPTH),
        .WIDTH (RES_W)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (back_push),
        .i_data  (back_res),
        .o_full  (out_q_full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (out_q_data)
    );

    assign head_res     = t_res'(out_q_data);
    assign o_status     = head_res.status;
    assign o_code_point = head_res.code_point;
    assign o_seq_length = head_res.seq_length;

endmodule

// ===== sim/tb_utf8_stream_decoder.sv =====
// ----------------------------------------------------------------------------
// tb_utf8_stream_decoder
// self-checking bench for the strict utf-8 stream decoder
// ----------------------------------------------------------------------------
// A queue of raw bytes feeds a falling-edge driver on the push/full side. A
// rising-edge monitor decodes every accepted byte with its own copy of the
// decoder state and queues the expected status, code point and length. Every
// result popped from the block is checked against the oldest expectation. The
// stimulus opens with directed bytes: ascii extremes, bad leads, each
// restricted second-byte range and a broken sequence. It goes on with random
// scalars encoded as utf-8, mixed with noise bytes and cut-off sequences.
// Both sides idle at random, except in one burst window.
`timescale 1ns / 1ps

module tb_utf8_stream_decoder;
    import u8d_pkg::*;

    localparam logic [7:0] ASCII_MAX   = 8'h7F;
    localparam logic [7:0] CONT_LO     = 8'h80;
    localparam int         N_RANDOM    = 900;
    localparam int         STALL_LIMIT = 5000;

    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        push         = 1'b0;
    logic        pop          = 1'b0;
    logic [7:0]  i_data_byte  = 8'h00;
    logic        full;
    logic        empty;
    logic [1:0]  o_status;
    logic [20:0] o_code_point;
    logic [2:0]  o_seq_length;

    logic [7:0] byte_queue [$];
    t_res       expected_results [$];
    int         n_queued   = 0;
    int         n_accepted = 0;
    int         n_fail     = 0;
    int         stall_cycles = 0;
    logic       burst;

    logic [1:0]  dec_left = 2'd0;
    logic [2:0]  dec_len  = 3'd0;
    logic [1:0]  dec_seen = 2'd0;
    logic [20:0] dec_bits = 21'd0;
    logic [7:0]  dec_lo   = CONT_LO;
    logic [7:0]  dec_hi   = B_CONT_HI;

    logic [7:0]  directed_bytes [27] = '{
        8'h00, 8'h7F, 8'h80, 8'hC1, 8'hF5, 8'hFF,
        8'hC2, 8'h80, 8'hDF, 8'hBF,
        8'hE0, 8'hA0, 8'h80, 8'hE0, 8'h9F,
        8'hED, 8'hA0,
        8'hF0, 8'h90, 8'h80, 8'h80,
        8'hF4, 8'h90, 8'hF4, 8'h8F, 8'hC2, 8'h41
    };
    logic [20:0] edge_scalars [10] = '{
        21'h00000, 21'h0007F, 21'h00080, 21'h007FF, 21'h00800,
        21'h0D7FF, 21'h0E000, 21'h0FFFF, 21'h10000, 21'h10FFFF
    };

    utf8_stream_decoder dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_data_byte  (i_data_byte),
        .empty        (empty),
        .pop          (pop),
        .o_status     (o_status),
        .o_code_point (o_code_point),
        .o_seq_length (o_seq_length)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    function automatic void clear_decoder();
        dec_left = 2'd0;
        dec_len  = 3'd0;
        dec_seen = 2'd0;
        dec_bits = 21'd0;
        dec_lo   = CONT_LO;
        dec_hi   = B_CONT_HI;
    endfunction

    function automatic void open_sequence(input logic [1:0] more, input logic [20:0] bits,
                                          input logic [7:0] lo, input logic [7:0] hi);
        dec_left = more;
        dec_len  = {1'b0, more} + 3'd1;
        dec_seen = 2'd1;
        dec_bits = bits;
        dec_lo   = lo;
        dec_hi   = hi;
    endfunction

    function automatic t_res decode_byte(input logic [7:0] b);
        t_res       r;
        logic [7:0] lo;
        logic [7:0] hi;
        r = '0;
        r.status = ST_PENDING;
        if (dec_left == 2'd0) begin
            if (b <= ASCII_MAX) begin
                r.status     = ST_DONE;
                r.code_point = {13'd0, b};
                r.seq_length = 3'd1;
                clear_decoder();
            end else if (b >= B_LEAD2_LO && b <= B_LEAD2_HI) begin
                open_sequence(2'd1, {16'd0, b[4:0]}, CONT_LO, B_CONT_HI);
            end else if (b >= B_LEAD3_LO && b <= B_LEAD3_HI) begin
                open_sequence(2'd2, {17'd0, b[3:0]},
                              (b == B_E0) ? B_SEC_A0 : CONT_LO,
                              (b == B_ED) ? B_SEC_9F : B_CONT_HI);
            end else if (b >= B_LEAD4_LO && b <= B_LEAD4_HI) begin
                open_sequence(2'd3, {18'd0, b[2:0]},
                              (b == B_F0) ? B_SEC_90 : CONT_LO,
                              (b == B_F4) ? B_SEC_8F : B_CONT_HI);
            end else begin
                r.status = ST_ILLEGAL;
                clear_decoder();
            end
        end else begin
            lo = (dec_seen == 2'd1) ? dec_lo : CONT_LO;
            hi = (dec_seen == 2'd1) ? dec_hi : B_CONT_HI;
            if (b < lo || b > hi) begin
                r.status = ST_ILLEGAL;
                clear_decoder();
            end else begin
                dec_bits = {dec_bits[14:0], b[5:0]};
                dec_left = dec_left - 2'd1;
                dec_seen = dec_seen + 2'd1;
                if (dec_left == 2'd0) begin
                    r.status     = ST_DONE;
                    r.code_point = dec_bits;
                    r.seq_length = dec_len;
                    clear_decoder();
                end
            end
        end
        return r;
    endfunction

    task automatic add_byte(input logic [7:0] b);
        byte_queue.push_back(b);
        n_queued++;
    endtask

    // utf-8 encoding of cp, cut after the first keep bytes
    task automatic add_scalar(input logic [20:0] cp, input int keep);
        logic [7:0] enc [4];
        int         n;
        if (cp < CP_MIN_2) begin
            n = 1;
            enc[0] = cp[7:0];
        end else if (cp < CP_MIN_3) begin
            n = 2;
            enc[0] = {3'b110, cp[10:6]};
            enc[1] = {2'b10, cp[5:0]};
        end else if (cp < CP_MIN_4) begin
            n = 3;
            enc[0] = {4'b1110, cp[15:12]};
            enc[1] = {2'b10, cp[11:6]};
            enc[2] = {2'b10, cp[5:0]};
        end else begin
            n = 4;
            enc[0] = {5'b11110, cp[20:18]};
            enc[1] = {2'b10, cp[17:12]};
            enc[2] = {2'b10, cp[11:6]};
            enc[3] = {2'b10, cp[5:0]};
        end
        for (int k = 0; k < n && k < keep; k++) begin
            add_byte(enc[k]);
        end
    endtask

    function automatic logic [20:0] random_scalar();
        logic [20:0] cp;
        if ($urandom_range(7) == 0) begin
            cp = edge_scalars[$urandom_range(9)];
        end else begin
            case ($urandom_range(3))
                0: begin
                    cp = 21'($urandom_range(32'h7F));
                end
                1: begin
                    cp = 21'($urandom_range(32'h7FF, 32'h80));
                end
                2: begin
                    do begin
                        cp = 21'($urandom_range(32'hFFFF, 32'h800));
                    end while (cp >= CP_SUR_LO && cp <= CP_SUR_HI);
                end
                default: begin
                    cp = 21'($urandom_range(32'h10FFFF, 32'h10000));
                end
            endcase
        end
        return cp;
    endfunction

    task automatic add_random_words(input int upto);
        while (n_queued < upto) begin
            case ($urandom_range(9))
                0: begin
                    add_byte(8'($urandom_range(255)));
                end
                1: begin
                    add_scalar(random_scalar(), $urandom_range(3, 1));
                end
                2: begin
                    add_byte(8'($urandom_range(32'hF4, 32'hC2)));
                    add_byte(8'($urandom_range(255)));
                end
                default: begin
                    add_scalar(random_scalar(), 4);
                end
            endcase
        end
    endtask

    task automatic drain_all();
        while (byte_queue.size() != 0 || expected_results.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    assign burst = (n_accepted >= 300) && (n_accepted < 500);

    always @(negedge i_clk) begin
        if (!i_rst_n || byte_queue.size() == 0 || (!burst && $urandom_range(99) < 19)) begin
            push <= 1'b0;
        end else begin
            push        <= 1'b1;
            i_data_byte <= byte_queue[0];
        end
        pop <= i_rst_n && (burst || $urandom_range(99) >= 19);
    end

    always @(posedge i_clk) begin
        t_res want;
        if (i_rst_n) begin
            if (push && !full) begin
                expected_results.push_back(decode_byte(i_data_byte));
                void'(byte_queue.pop_front());
                n_accepted++;
            end
            if (pop && !empty) begin
                if (expected_results.size() == 0) begin
                    $error("result word with no expectation waiting");
                    n_fail++;
                end else begin
                    want = expected_results.pop_front();
                    if (o_status !== want.status) begin
                        $error("o_status mismatch: expected %0d, actual %0d",
                               want.status, o_status);
                        n_fail++;
                    end
                    if (o_code_point !== want.code_point) begin
                        $error("o_code_point mismatch: expected %0h, actual %0h",
                               want.code_point, o_code_point);
                        n_fail++;
                    end
                    if (o_seq_length !== want.seq_length) begin
                        $error("o_seq_length mismatch: expected %0d, actual %0d",
                               want.seq_length, o_seq_length);
                        n_fail++;
                    end
                end
            end
            if ((push && !full) || (pop && !empty)) begin
                stall_cycles <= 0;
            end else if (stall_cycles >= STALL_LIMIT) begin
                $display("status: fail");
                $finish;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    initial begin
        foreach (directed_bytes[k]) begin
            add_byte(directed_bytes[k]);
        end
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        drain_all();
        add_random_words(n_queued + N_RANDOM / 2);
        // sender holds off until every result is out
        drain_all();
        add_random_words(n_queued + N_RANDOM / 2);
        drain_all();
        repeat (8) @(posedge i_clk);
        if (expected_results.size() != 0) begin
            $error("expectations left over at the end");
            n_fail++;
        end
        if (n_fail == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
